/* sv/gha_pkg.sv */
// shared types and constants for the generational handle allocator
package gha_pkg;

	localparam int MAX_SLOTS_DEF       = 256;
	localparam int PENDING_DEPTH_DEF   = 32;
	localparam int SLOT_FIELD_BITS_DEF = 16;

	localparam logic [2:0] REQ_CREATE  = 3'd0;
	localparam logic [2:0] REQ_UPDATE  = 3'd1;
	localparam logic [2:0] REQ_QUERY   = 3'd2;
	localparam logic [2:0] REQ_DESTROY = 3'd3;
	localparam logic [2:0] REQ_FRAME   = 3'd4;
	localparam logic [2:0] REQ_FLUSH   = 3'd5;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_INVALID      = 3'd1;
	localparam logic [2:0] ST_NOT_READY    = 3'd2;
	localparam logic [2:0] ST_FULL         = 3'd3;
	localparam logic [2:0] ST_PENDING_FULL = 3'd4;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_PREAD,
		S_PWAIT,
		S_PSLOT,
		S_PEXEC,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;       // write one table row to zero at the sweep address
		logic capture;     // latch the request
		logic table_rd;    // read the slot addressed by the request handle, or the slot to allocate for a create
		logic exec;        // apply create/update/query/destroy
		logic pend_start;  // reset queue walk pointers
		logic pend_rd;     // read queue entry at walk pointer
		logic pslot_rd;    // read the slot of the current queue entry
		logic pexec;       // reclaim, keep or drop the current queue entry
		logic pend_finish; // set the fill count to the kept count
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
		logic walk_done;
		logic is_walk;
	} sts_t;

endpackage

/* sv/gha_if.sv */
// valid/ready channel carrying a request or a result
interface gha_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] handle;
	logic [31:0] capacity;
	logic [31:0] instance_count;
	logic [63:0] fence;
	modport source (output valid, req_type, handle, capacity, instance_count, fence,
		input ready);
	modport sink (input valid, req_type, handle, capacity, instance_count, fence,
		output ready);
endinterface

interface gha_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] handle_out;
	logic [31:0] count_out;
	logic [2:0]  status;
	logic [5:0]  reclaimed;
	modport source (output valid, handle_out, count_out, status, reclaimed, input ready);
	modport sink (input valid, handle_out, count_out, status, reclaimed, output ready);
endinterface

/* sv/generational_handle_allocator.sv */
// top level of the generational handle allocator
//  channel | dir | payload
//  req     | in  | req_type, handle, capacity, instance_count, fence
//  rsp     | out | handle_out, count_out, status, reclaimed
//  cfg     | in  | cfg_we, cfg_wdata (device_ready)
// create/update/query/destroy: the request passes the read, execute and output states
// frame begin and flush: the queue walk visits each queued entry in turn over one slot port
// after reset a clearing pass of one slot row a cycle (256 rows by default) holds off requests
// one request at a time; the next is taken after the result transfers
module generational_handle_allocator
	import gha_pkg::*;
#(
	parameter int MAX_SLOTS       = MAX_SLOTS_DEF,
	parameter int PENDING_DEPTH   = PENDING_DEPTH_DEF,
	parameter int SLOT_FIELD_BITS = SLOT_FIELD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	gha_req_if.sink   req,
	gha_rsp_if.source rsp
);

	cmd_t cmd;
	sts_t sts;
	logic device_ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_ready_q <= 1'b0;
		end else if (cfg_we) begin
			device_ready_q <= cfg_wdata;
		end
	end

	gha_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.sts, .cmd
	);

	gha_dp #(
		.MAX_SLOTS(MAX_SLOTS), .PENDING_DEPTH(PENDING_DEPTH),
		.SLOT_FIELD_BITS(SLOT_FIELD_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.device_ready(device_ready_q),
		.req_type(req.req_type), .handle(req.handle), .capacity(req.capacity),
		.instance_count(req.instance_count), .fence(req.fence),
		.handle_out(rsp.handle_out), .count_out(rsp.count_out),
		.status(rsp.status), .reclaimed(rsp.reclaimed)
	);

endmodule

/* sv/gha_ctrl.sv */
// controller state machine for the handle allocator
module gha_ctrl
	import gha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (sts.is_walk) begin
					cmd.pend_start = 1'b1;
					state_d = S_PREAD;
				end else begin
					cmd.table_rd = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = S_OUT;
			end
			S_PREAD: begin
				if (sts.walk_done) begin
					cmd.pend_finish = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.pend_rd = 1'b1;
					state_d = S_PWAIT;
				end
			end
			S_PWAIT: begin
				cmd.pslot_rd = 1'b1;
				state_d = S_PSLOT;
			end
			S_PSLOT: begin
				state_d = S_PEXEC;
			end
			S_PEXEC: begin
				cmd.pexec = 1'b1;
				state_d = S_PREAD;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before transfer");
	a_exec_then_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> (state_q == S_OUT))
		else $error("exec not followed by result");
`endif

endmodule

/* sv/gha_dp.sv */
// slot table, free stack and deferred free queue datapath
module gha_dp
	import gha_pkg::*;
#(
	parameter int MAX_SLOTS       = MAX_SLOTS_DEF,
	parameter int PENDING_DEPTH   = PENDING_DEPTH_DEF,
	parameter int SLOT_FIELD_BITS = SLOT_FIELD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        device_ready,
	input  logic [2:0]  req_type,
	input  logic [31:0] handle,
	input  logic [31:0] capacity,
	input  logic [31:0] instance_count,
	input  logic [63:0] fence,
	output logic [31:0] handle_out,
	output logic [31:0] count_out,
	output logic [2:0]  status,
	output logic [5:0]  reclaimed
);

	localparam int FIELD_MASK = (1 << SLOT_FIELD_BITS) - 1;
	localparam int USABLE = (MAX_SLOTS < FIELD_MASK) ? MAX_SLOTS : FIELD_MASK;
	localparam int SW = (USABLE > 1) ? $clog2(USABLE) : 1;
	localparam int CW = $clog2(USABLE + 1);
	localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int PC = $clog2(PENDING_DEPTH + 1);
	localparam int EW = SW + 16 + 64;

	// slot row: live, generation, count
	logic [48:0]   slot_mem [USABLE];
	logic [SW-1:0] free_mem [USABLE];
	logic [EW-1:0] pend_mem [PENDING_DEPTH];

	logic [CW-1:0] free_top_q, slots_used_q, clr_q;
	logic [PC-1:0] fill_q, rd_q, keep_q;
	logic [2:0]    req_q;
	logic [31:0]   handle_q, cap_q, cnt_q;
	logic [63:0]   fence_q;
	logic [48:0]   row_q;
	logic [SW-1:0] free_rd_q;
	logic [EW-1:0] ent_q;
	logic [5:0]    recl_q;
	logic [31:0]   hout_q, cout_q;
	logic [2:0]    st_q;

	logic [SLOT_FIELD_BITS-1:0] field;
	logic [15:0]   hgen;
	logic [31:0]   sidx;
	logic          hvalid;
	logic [SW-1:0] hslot;
	logic [SW-1:0] eslot;
	logic [15:0]   egen;
	logic [63:0]   efence;
	logic          ent_due, ent_ok;

	assign field = handle_q[SLOT_FIELD_BITS-1:0];
	assign hgen  = handle_q[SLOT_FIELD_BITS +: 16] & 16'hffff;
	assign sidx  = 32'(field) - 32'd1;
	assign hslot = sidx[SW-1:0];
	assign hvalid = (field != '0) && (sidx < 32'(slots_used_q))
		&& (row_q[47:32] == hgen) && row_q[48];

	assign eslot  = ent_q[EW-1 -: SW];
	assign egen   = ent_q[79:64];
	assign efence = ent_q[63:0];
	assign ent_due = (req_q == REQ_FLUSH) || (efence <= fence_q);
	assign ent_ok  = (32'(eslot) < 32'(slots_used_q)) && (row_q[47:32] == egen);

	assign sts.clear_done = (clr_q == CW'(USABLE - 1));
	assign sts.walk_done  = (rd_q >= fill_q);
	assign sts.is_walk    = (req_q == REQ_FRAME) || (req_q == REQ_FLUSH);

	// memory ports
	logic [SW-1:0] create_slot;
	assign create_slot = (free_top_q != '0) ? free_rd_q : slots_used_q[SW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.table_rd) begin
			row_q <= slot_mem[(req_q == REQ_CREATE) ? create_slot : hslot];
		end else if (cmd.pslot_rd) begin
			row_q <= slot_mem[eslot];
		end
		if (cmd.capture) begin
			free_rd_q <= free_mem[free_top_q[SW-1:0] - SW'(1)];
		end
		if (cmd.pend_rd) begin
			ent_q <= pend_mem[rd_q[PW-1:0]];
		end
		if (cmd.clear) begin
			slot_mem[clr_q[SW-1:0]] <= '0;
		end else if (cmd.exec) begin
			case (req_q)
				REQ_CREATE: begin
					if (device_ready && cap_q != '0
						&& (free_top_q != '0 || slots_used_q < CW'(USABLE))) begin
						slot_mem[create_slot] <= {1'b1, row_q[47:32], 32'd0};
					end
				end
				REQ_UPDATE: begin
					if (hvalid) begin
						slot_mem[hslot] <= {row_q[48:32], cnt_q};
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.pexec && ent_due && ent_ok) begin
			slot_mem[eslot] <= {1'b0, row_q[47:32] + 16'd1, row_q[31:0]};
		end
		if (cmd.exec && req_q == REQ_DESTROY && hvalid && fill_q < PC'(PENDING_DEPTH)) begin
			pend_mem[fill_q[PW-1:0]] <= {hslot, row_q[47:32], fence_q};
		end else if (cmd.pexec && !ent_due) begin
			pend_mem[keep_q[PW-1:0]] <= ent_q;
		end
		if (cmd.pexec && ent_due && ent_ok && free_top_q < CW'(USABLE)) begin
			free_mem[free_top_q[SW-1:0]] <= eslot;
		end
		if (cmd.capture) begin
			req_q <= req_type;
			handle_q <= handle;
			cap_q <= capacity;
			cnt_q <= instance_count;
			fence_q <= fence;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_top_q <= '0;
			slots_used_q <= '0;
			clr_q <= '0;
			fill_q <= '0;
			rd_q <= '0;
			keep_q <= '0;
			recl_q <= '0;
			hout_q <= '0;
			cout_q <= '0;
			st_q <= ST_OK;
		end else begin
			if (cmd.clear && !sts.clear_done) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cmd.capture) begin
				recl_q <= '0;
				hout_q <= '0;
				cout_q <= '0;
				st_q <= ST_OK;
			end
			if (cmd.exec) begin
				case (req_q)
					REQ_CREATE: begin
						if (!device_ready || cap_q == '0) begin
							st_q <= ST_NOT_READY;
						end else if (free_top_q != '0) begin
							free_top_q <= free_top_q - CW'(1);
							hout_q <= {row_q[47:32], 16'd0} >> (16 - SLOT_FIELD_BITS)
								| 32'(create_slot) + 32'd1;
						end else if (slots_used_q < CW'(USABLE)) begin
							slots_used_q <= slots_used_q + CW'(1);
							hout_q <= {row_q[47:32], 16'd0} >> (16 - SLOT_FIELD_BITS)
								| 32'(create_slot) + 32'd1;
						end else begin
							st_q <= ST_FULL;
						end
					end
					REQ_UPDATE: begin
						if (!hvalid) st_q <= ST_INVALID;
					end
					REQ_QUERY: begin
						if (hvalid) cout_q <= row_q[31:0];
						else st_q <= ST_INVALID;
					end
					REQ_DESTROY: begin
						if (!hvalid) begin
							st_q <= ST_INVALID;
						end else if (fill_q >= PC'(PENDING_DEPTH)) begin
							st_q <= ST_PENDING_FULL;
						end else begin
							fill_q <= fill_q + PC'(1);
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.pend_start) begin
				rd_q <= '0;
				keep_q <= '0;
			end
			if (cmd.pexec) begin
				rd_q <= rd_q + PC'(1);
				if (!ent_due) begin
					keep_q <= keep_q + PC'(1);
				end else if (ent_ok) begin
					if (free_top_q < CW'(USABLE)) free_top_q <= free_top_q + CW'(1);
					if (recl_q != 6'd63) recl_q <= recl_q + 6'd1;
				end
			end
			if (cmd.pend_finish) begin
				fill_q <= keep_q;
			end
		end
	end

	assign handle_out = hout_q;
	assign count_out  = cout_q;
	assign status     = st_q;
	assign reclaimed  = recl_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PC'(PENDING_DEPTH))
		else $error("queue fill over depth");
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_top_q <= slots_used_q)
		else $error("free stack deeper than used slots");
	a_keep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		keep_q <= rd_q)
		else $error("kept more entries than walked");
`endif

endmodule

/* bench/tb.sv */
// self-checking bench for the generational handle allocator
module tb
	import gha_pkg::*;
();

	localparam int NSLOT = 256;
	localparam int NPEND = 32;

	typedef struct {
		logic [31:0] handle_out;
		logic [31:0] count_out;
		logic [2:0]  status;
		logic [5:0]  reclaimed;
	} rsp_t;

	typedef struct {
		int unsigned slot;
		logic [15:0] gen;
		logic [63:0] fence;
	} pend_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	gha_req_if req ();
	gha_rsp_if rsp ();

	generational_handle_allocator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req.sink), .rsp(rsp.source)
	);

	// predictor state
	bit          live_m [NSLOT];
	logic [15:0] gen_m [NSLOT];
	logic [31:0] cnt_m [NSLOT];
	int unsigned free_m [$];
	int unsigned used_m;
	pend_t       pend_m [$];
	bit          ready_m;

	rsp_t        expected_rsp [$];
	logic [31:0] live_handles [$];
	logic [31:0] dead_handles [$];
	int          errors;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	function automatic bit handle_ok(logic [31:0] h, output int unsigned s);
		logic [15:0] f;
		f = h[15:0];
		s = 0;
		if (h == 0 || f == 0) return 0;
		s = f - 1;
		if (s >= used_m) return 0;
		if (gen_m[s] != h[31:16]) return 0;
		return live_m[s];
	endfunction

	function automatic int unsigned reclaim_one(pend_t p);
		if (p.slot >= used_m || gen_m[p.slot] != p.gen) return 0;
		live_m[p.slot] = 0;
		gen_m[p.slot] = gen_m[p.slot] + 1;
		free_m.insert(free_m.size(), p.slot);
		return 1;
	endfunction

	function automatic rsp_t predict_alloc(logic [2:0] rt, logic [31:0] h, logic [31:0] cap,
		logic [31:0] ic, logic [63:0] fe);
		rsp_t r;
		int unsigned s, recl;
		pend_t keep [$];
		pend_t p;
		r = '{0, 0, ST_OK, 0};
		recl = 0;
		case (rt)
			REQ_CREATE: begin
				if (!ready_m || cap == 0) r.status = ST_NOT_READY;
				else if (free_m.size() > 0) begin
					s = free_m[free_m.size() - 1];
					free_m.delete(free_m.size() - 1);
				end else if (used_m < NSLOT) begin
					s = used_m;
					used_m++;
				end else r.status = ST_FULL;
				if (r.status == ST_OK) begin
					live_m[s] = 1;
					cnt_m[s] = 0;
					r.handle_out = {gen_m[s], 16'(s + 1)};
				end
			end
			REQ_UPDATE: if (handle_ok(h, s)) cnt_m[s] = ic; else r.status = ST_INVALID;
			REQ_QUERY: if (handle_ok(h, s)) r.count_out = cnt_m[s]; else r.status = ST_INVALID;
			REQ_DESTROY: begin
				if (!handle_ok(h, s)) r.status = ST_INVALID;
				else if (pend_m.size() >= NPEND) r.status = ST_PENDING_FULL;
				else begin
					p.slot = s;
					p.gen = gen_m[s];
					p.fence = fe;
					pend_m.insert(pend_m.size(), p);
				end
			end
			REQ_FRAME: begin
				foreach (pend_m[i])
					if (pend_m[i].fence <= fe) recl += reclaim_one(pend_m[i]);
					else keep.insert(keep.size(), pend_m[i]);
				pend_m = keep;
			end
			REQ_FLUSH: begin
				foreach (pend_m[i]) recl += reclaim_one(pend_m[i]);
				pend_m.delete();
			end
			default: ;
		endcase
		r.reclaimed = (recl > 63) ? 6'd63 : 6'(recl);
		return r;
	endfunction

	// valid stays up between back to back requests, dropped only before an idle gap
	task automatic send_request(logic [2:0] rt, logic [31:0] h, logic [31:0] cap,
		logic [31:0] ic, logic [63:0] fe);
		rsp_t r;
		int idle;
		idle = $urandom_range(0, 6);
		if (idle != 0) begin
			req.valid <= 0;
			repeat (idle) @(posedge clk);
		end
		req.valid <= 1;
		req.req_type <= rt;
		req.handle <= h;
		req.capacity <= cap;
		req.instance_count <= ic;
		req.fence <= fe;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		r = predict_alloc(rt, h, cap, ic, fe);
		expected_rsp.insert(expected_rsp.size(), r);
		if (rt == REQ_CREATE && r.status == ST_OK)
			live_handles.insert(live_handles.size(), r.handle_out);
	endtask

	task automatic set_device_ready(bit v);
		req.valid <= 0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		ready_m = v;
	endtask

	// picks a handle: mostly issued ones, some stale, some noise
	function automatic logic [31:0] pick_handle();
		int k;
		k = $urandom_range(0, 9);
		if (k < 7 && live_handles.size() > 0)
			return live_handles[$urandom_range(0, live_handles.size() - 1)];
		if (k < 9 && dead_handles.size() > 0)
			return dead_handles[$urandom_range(0, dead_handles.size() - 1)];
		return $urandom;
	endfunction

	// response checker with random stall
	initial begin
		rsp_t e;
		int idle;
		rsp.ready <= 0;
		@(posedge arst_n);
		forever begin
			idle = $urandom_range(0, 6);
			if (idle != 0) begin
				rsp.ready <= 0;
				repeat (idle) @(posedge clk);
			end
			rsp.ready <= 1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
			if (expected_rsp.size() == 0) begin
				$display("%0t unexpected result", $time);
				errors++;
			end else begin
				e = expected_rsp.pop_front();
				if (rsp.handle_out !== e.handle_out || rsp.count_out !== e.count_out ||
					rsp.status !== e.status || rsp.reclaimed !== e.reclaimed) begin
					$display("%0t expected h=%h c=%h st=%0d r=%0d actual h=%h c=%h st=%0d r=%0d",
						$time, e.handle_out, e.count_out, e.status, e.reclaimed,
						rsp.handle_out, rsp.count_out, rsp.status, rsp.reclaimed);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_request(REQ_CREATE, 0, 5, 0, 0);
		send_request(REQ_QUERY, 0, 0, 0, 0);
		set_device_ready(1);
		send_request(REQ_CREATE, 0, 0, 0, 0);
		send_request(REQ_CREATE, 0, 32'hffffffff, 0, 0);
		send_request(REQ_CREATE, 0, 1, 0, 0);
		send_request(REQ_UPDATE, live_handles[0], 0, 32'hffffffff, 0);
		send_request(REQ_QUERY, live_handles[0], 0, 0, 0);
		send_request(REQ_UPDATE, 32'hffffffff, 0, 7, 0);
		send_request(REQ_QUERY, 32'h00010001, 0, 0, 0);
		send_request(REQ_DESTROY, live_handles[0], 0, 0, 64'hffffffffffffffff);
		send_request(REQ_DESTROY, live_handles[1], 0, 0, 0);
		send_request(REQ_DESTROY, live_handles[1], 0, 0, 5);
		send_request(REQ_FRAME, 0, 0, 0, 0);
		send_request(REQ_QUERY, live_handles[0], 0, 0, 0);
		send_request(REQ_FLUSH, 0, 0, 0, 0);
		send_request(REQ_QUERY, live_handles[0], 0, 0, 0);
		send_request(3'd6, 32'hffffffff, 1, 1, 1);
		send_request(3'd7, 0, 0, 0, 0);
		dead_handles = live_handles;
		live_handles.delete();
	endtask

	// fill the table to full and pending queue past full
	task automatic test_capacity();
		for (int i = 0; i < 260; i++) send_request(REQ_CREATE, 0, $urandom | 1, 0, 0);
		for (int i = 0; i < 34; i++) send_request(REQ_DESTROY, live_handles[i], 0, 0, i);
		send_request(REQ_FRAME, 0, 0, 0, 64'd20);
		send_request(REQ_FLUSH, 0, 0, 0, 0);
	endtask

	task automatic test_random(int n);
		logic [2:0] rt;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 25) rt = REQ_CREATE;
			else if (k < 40) rt = REQ_UPDATE;
			else if (k < 55) rt = REQ_QUERY;
			else if (k < 78) rt = REQ_DESTROY;
			else if (k < 92) rt = REQ_FRAME;
			else if (k < 97) rt = REQ_FLUSH;
			else rt = 3'($urandom_range(6, 7));
			send_request(rt, pick_handle(), ($urandom_range(0, 15) == 0) ? 0 : $urandom,
				$urandom, ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} :
				64'($urandom_range(0, 64)));
			if (live_handles.size() > 64)
				dead_handles.insert(dead_handles.size(), live_handles.pop_front());
			if (dead_handles.size() > 64) void'(dead_handles.pop_front());
		end
	endtask

	initial begin
		errors = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		req.valid = 0;
		req.req_type = 0;
		req.handle = 0;
		req.capacity = 0;
		req.instance_count = 0;
		req.fence = 0;
		used_m = 0;
		ready_m = 0;
		foreach (live_m[i]) begin
			live_m[i] = 0;
			gen_m[i] = 0;
			cnt_m[i] = 0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_capacity();
		test_random(700);
		set_device_ready(0);
		test_random(200);
		set_device_ready(1);
		test_random(700);
		req.valid <= 0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
